[rtl/core/lpd_pkg.sv]
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefix deframer with ascii
// fallback: header phases, route codes and the queue entry format.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;

  // Reset value of the largest accepted inner length
  localparam logic [LEN_W-1:0] MAX_INNER_RESET = 16'd768;

  // Route tags on the result stream
  localparam logic ROUTE_BINARY = 1'b0;
  localparam logic ROUTE_ASCII  = 1'b1;

  // Front-end parse phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BINARY = 2'd1,
    PH_ASCII  = 2'd2
  } lpd_phase_t;

  // One queue entry: either a single byte (in byte2) or a burst of three
  typedef struct packed {
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
    logic              triple;
    logic              route;
    logic              last;
  } lpd_entry_t;

endpackage

[rtl/core/lpd_front.sv]
// ----------------------------------------------------------------------------
// lpd_front
// Accepts received bytes, collects the two-byte length header, classifies
// the frame as binary or ascii and pushes byte groups into the queue.
// ----------------------------------------------------------------------------
module lpd_front
  import lpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // received byte stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] rx_byte
  input  logic              in_tlast,   // packet_end
  // configuration write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data,   // [15:0] max_inner_len
  // queue push side
  output logic              push,
  output lpd_entry_t        push_entry,
  input  logic              full
);

  lpd_phase_t        phase_r, phase_nxt;
  logic [BYTE_W-1:0] held0_r, held0_nxt;
  logic [BYTE_W-1:0] held1_r, held1_nxt;
  logic [1:0]        held_cnt_r, held_cnt_nxt;
  logic [LEN_W-1:0]  remain_r, remain_nxt;
  logic [LEN_W-1:0]  max_len_r;

  logic              accept;
  logic [LEN_W-1:0]  hdr_len;
  logic              hdr_ascii;
  logic [LEN_W-1:0]  remain_dec;

  assign in_tready  = ~full;
  assign cfg_ready  = 1'b1;
  assign accept     = in_tvalid & in_tready;
  assign hdr_len    = {held1_r, held0_r};
  assign hdr_ascii  = (hdr_len == '0) || (hdr_len > max_len_r);
  assign remain_dec = (remain_r != '0) ? remain_r - 16'd1 : remain_r;

  // Hold the length limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_INNER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_data;
    end
  end

  // Next parse state
  always_comb begin
    phase_nxt    = phase_r;
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    held_cnt_nxt = held_cnt_r;
    remain_nxt   = remain_r;
    if (accept) begin
      unique case (phase_r)
        PH_BINARY: begin
          remain_nxt = remain_dec;
          if (remain_dec == '0) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_ASCII: begin
          if (in_tlast) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
          if (held_cnt_r < 2'd2) begin
            if (held_cnt_r[0]) begin
              held1_nxt = in_tdata;
            end else begin
              held0_nxt = in_tdata;
            end
            held_cnt_nxt = held_cnt_r + 2'd1;
          end else begin
            held_cnt_nxt = 2'd0;
            if (hdr_ascii) begin
              phase_nxt = in_tlast ? PH_HEADER : PH_ASCII;
            end else begin
              remain_nxt = hdr_len - 16'd1;
              phase_nxt  = (hdr_len == 16'd1) ? PH_HEADER : PH_BINARY;
            end
          end
        end
      endcase
    end
  end

  // Queue push for the accepted byte
  always_comb begin
    push              = 1'b0;
    push_entry.byte0  = held0_r;
    push_entry.byte1  = held1_r;
    push_entry.byte2  = in_tdata;
    push_entry.triple = 1'b0;
    push_entry.route  = ROUTE_BINARY;
    push_entry.last   = 1'b0;
    unique case (phase_r)
      PH_BINARY: begin
        push            = accept;
        push_entry.last = (remain_dec == '0);
      end
      PH_ASCII: begin
        push             = accept;
        push_entry.route = ROUTE_ASCII;
        push_entry.last  = in_tlast;
      end
      default: begin
        push              = accept && (held_cnt_r >= 2'd2);
        push_entry.triple = 1'b1;
        if (hdr_ascii) begin
          push_entry.route = ROUTE_ASCII;
          push_entry.last  = in_tlast;
        end else begin
          push_entry.last  = (hdr_len == 16'd1);
        end
      end
    endcase
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      held_cnt_r <= 2'd0;
      remain_r   <= '0;
      held0_r    <= '0;
      held1_r    <= '0;
    end else begin
      phase_r    <= phase_nxt;
      held_cnt_r <= held_cnt_nxt;
      remain_r   <= remain_nxt;
      held0_r    <= held0_nxt;
      held1_r    <= held1_nxt;
    end
  end

endmodule

[rtl/core/lpd_queue.sv]
// ----------------------------------------------------------------------------
// lpd_queue
// Small FIFO of byte groups between the parsing front end and the
// serializing back end.
// ----------------------------------------------------------------------------
module lpd_queue
  import lpd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lpd_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output lpd_entry_t head,
  output logic       empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lpd_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rd_ptr_r];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/lpd_back.sv]
// ----------------------------------------------------------------------------
// lpd_back
// Takes byte groups from the queue and sends them one byte per cycle, while
// out_tready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module lpd_back
  import lpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // queue pop side
  input  lpd_entry_t head,
  input  logic       empty,
  output logic       pop,
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tuser,   // route
  output logic       out_tlast    // unit_last
);

  logic [1:0]        idx_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_route_r;
  logic              out_last_r;

  logic              load;
  logic              final_byte;
  logic [BYTE_W-1:0] cur_byte;

  assign load       = (~out_valid_r | out_tready) & ~empty;
  assign final_byte = ~head.triple | (idx_r == 2'd2);
  assign pop        = load & final_byte;

  // Select the byte of the head group
  always_comb begin
    case (idx_r)
      2'd0:    cur_byte = head.triple ? head.byte0 : head.byte2;
      2'd1:    cur_byte = head.byte1;
      default: cur_byte = head.byte2;
    endcase
  end

  // Advance within the group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (load) begin
      idx_r <= final_byte ? 2'd0 : idx_r + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r  <= cur_byte;
      out_route_r <= head.route;
      out_last_r  <= head.last & final_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_route_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/core/length_prefix_deframer_ascii_fallback.sv]
// ----------------------------------------------------------------------------
// length_prefix_deframer_ascii_fallback
// Deframes a received byte stream into little-endian length-prefixed
// binary frames, falling back to ascii runs up to the packet end.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata         | tuser | tlast
//  in_     | input     | rx_byte [7:0] | -     | packet_end
//  out_    | output    | out_byte[7:0] | route | unit_last
//  cfg_    | input     | max_inner_len | -     | -
//
//  One byte per cycle in and out sustained while the queue is not full and
//  out_tready is high. Header bytes produce nothing; the first byte after a
//  header produces three results (both header bytes and itself), sent one
//  at a time by the back end from the queue. A three-byte group at the head
//  of a full queue holds the input until its last byte is loaded into the
//  output register. Synchronous active-low reset clears all control state and
//  restores max_inner_len to 768. in_tready drops only when the queue is full.
// ----------------------------------------------------------------------------
module length_prefix_deframer_ascii_fallback
  import lpd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        in_tlast,    // packet_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tuser,   // route
  output logic        out_tlast,   // unit_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data     // [15:0] max_inner_len
);

  logic       push, pop, full, empty;
  lpd_entry_t push_entry, head;

  lpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  lpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  lpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
